[design/sorted_weekly_event_table_defines.svh]
// assertion shorthands used by the sorted weekly event table design
`ifndef SORTED_WEEKLY_EVENT_TABLE_DEFINES_SVH
`define SORTED_WEEKLY_EVENT_TABLE_DEFINES_SVH

// plain invariant, checked at every rising clock edge out of reset
`define SWET_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define SWET_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SWET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/swet_pkg.sv]
`timescale 1ns / 1ps

package swet_pkg;

  localparam int unsigned KEY_W = 20;

  localparam logic OP_INSERT  = 1'b0;
  localparam logic OP_REFRESH = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  // day, hour, minute, second from msb down: packed order is sort order
  typedef struct packed {
    logic [2:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } key_t;

  typedef struct packed {
    logic       op;
    logic [2:0] entry_day;
    logic [4:0] entry_hour;
    logic [5:0] entry_minute;
    logic [5:0] entry_second;
    logic [2:0] now_raw_day;
    logic [4:0] now_hour;
    logic [5:0] now_minute;
    logic [5:0] now_second;
  } in_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
    logic [3:0] next_index;
    logic [2:0] next_day;
    logic [4:0] next_hour;
    logic [5:0] next_minute;
    logic [5:0] next_second;
  } out_rsp_t;

  // clock counts sunday as 0, table counts monday as 0: (d + 6) mod 7
  function automatic logic [2:0] map_day(input logic [2:0] raw_day);
    logic [2:0] res;
    if (raw_day == 3'd0) begin
      res = 3'd6;
    end else begin
      res = raw_day - 3'd1;
    end
    return res;
  endfunction

endpackage

[design/swet_ram.sv]
`timescale 1ns / 1ps

module swet_ram #(
  parameter int unsigned WIDTH = 20,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/sorted_weekly_event_table.sv]
`timescale 1ns / 1ps
`include "sorted_weekly_event_table_defines.svh"

// Sorted weekly event table. Holds up to TABLE_DEPTH events in ascending
// (day, hour, minute, second) order in one synchronous RAM and returns one
// result per request: status, entry count, and the next upcoming entry (the
// first one strictly later than the request's current time, index 0 if none;
// a rejected insert keeps the index found by the last search instead).
// Requests are handled one at a time; all work goes through the single RAM
// read port. An insert does a duplicate scan, a shift of larger entries and
// a next-event scan, a rejected insert only the duplicate scan. The next
// request is taken while a finished result still waits on the output. No
// clearing pass after reset: entries at or above the count are never used.
module sorted_weekly_event_table #(
  parameter int unsigned TABLE_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  swet_pkg::in_req_t  in_req_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  output swet_pkg::out_rsp_t out_rsp_o,
  input  logic               out_stall_i
);

  localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KW = swet_pkg::KEY_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DUP,
    S_SHIFT,
    S_PLACE,
    S_NEXT,
    S_FETCH,
    S_OUT
  } state_e;

  state_e             state_q, state_d;
  swet_pkg::in_req_t  req_q, req_d;
  swet_pkg::status_e  status_q, status_d;
  swet_pkg::out_rsp_t out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      up_q, up_d;
  logic [CW-1:0]      rd_idx_q, rd_idx_d;
  logic               pend_q, pend_d;
  logic [IW-1:0]      pend_idx_q, pend_idx_d;
  logic               dup_q, dup_d;
  logic               found_q, found_d;
  logic [IW-1:0]      found_idx_q, found_idx_d;
  logic [KW-1:0]      found_key_q, found_key_d;
  logic [KW-1:0]      first_key_q, first_key_d;
  logic [CW-1:0]      ins_q, ins_d;
  logic [KW-1:0]      nk_q, nk_d;

  logic               ram_we, ram_re;
  logic [IW-1:0]      ram_waddr, ram_raddr;
  logic [KW-1:0]      ram_wdata, ram_rdata;

  logic [KW-1:0]      new_key, now_key;
  logic [CW-1:0]      cnt_m1, ins_m1, ins_m2;
  logic               issue, match, hit;
  swet_pkg::key_t     nk_fields;

  assign new_key = {req_q.entry_day, req_q.entry_hour, req_q.entry_minute, req_q.entry_second};
  assign now_key = {swet_pkg::map_day(req_q.now_raw_day), req_q.now_hour,
                    req_q.now_minute, req_q.now_second};
  assign cnt_m1  = count_q - CW'(1);
  assign ins_m1  = ins_q - CW'(1);
  assign ins_m2  = ins_m1 - CW'(1);
  assign issue   = (rd_idx_q < count_q);
  assign match   = pend_q && (ram_rdata == new_key);
  assign hit     = pend_q && (now_key < ram_rdata);
  assign nk_fields = swet_pkg::key_t'(nk_q);

  swet_ram #(
    .WIDTH(KW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // reads and writes never hit the same entry in one cycle: the shift writes
  // slot i while reading slot i-2, and scans never write
  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    status_d    = status_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    count_d     = count_q;
    up_d        = up_q;
    rd_idx_d    = rd_idx_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    dup_d       = dup_q;
    found_d     = found_q;
    found_idx_d = found_idx_q;
    found_key_d = found_key_q;
    first_key_d = first_key_q;
    ins_d       = ins_q;
    nk_d        = nk_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = new_key;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d    = in_req_i;
          status_d = swet_pkg::ST_DONE;
          rd_idx_d = '0;
          pend_d   = 1'b0;
          dup_d    = 1'b0;
          found_d  = 1'b0;
          state_d  = (in_req_i.op == swet_pkg::OP_INSERT) ? S_DUP : S_NEXT;
        end
      end
      S_DUP: begin
        if (match) begin
          dup_d = 1'b1;
        end
        if (issue) begin
          ram_re    = 1'b1;
          ram_raddr = rd_idx_q[IW-1:0];
          pend_d    = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (dup_q || match || (count_q == DEPTH_C)) begin
            status_d  = (dup_q || match) ? swet_pkg::ST_DUP : swet_pkg::ST_FULL;
            ram_re    = 1'b1;
            ram_raddr = up_q;
            state_d   = S_FETCH;
          end else begin
            ins_d = count_q;
            if (count_q != '0) begin
              ram_re    = 1'b1;
              ram_raddr = cnt_m1[IW-1:0];
              state_d   = S_SHIFT;
            end else begin
              state_d = S_PLACE;
            end
          end
        end
      end
      S_SHIFT: begin
        // read data holds the entry just below the hole at ins_q
        if (ram_rdata > new_key) begin
          ram_we    = 1'b1;
          ram_waddr = ins_q[IW-1:0];
          ram_wdata = ram_rdata;
          ins_d     = ins_m1;
          if (ins_q > CW'(1)) begin
            ram_re    = 1'b1;
            ram_raddr = ins_m2[IW-1:0];
          end else begin
            state_d = S_PLACE;
          end
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = ins_q[IW-1:0];
        ram_wdata = new_key;
        count_d   = count_q + CW'(1);
        rd_idx_d  = '0;
        pend_d    = 1'b0;
        found_d   = 1'b0;
        state_d   = S_NEXT;
      end
      S_NEXT: begin
        if (hit && !found_q) begin
          found_d     = 1'b1;
          found_idx_d = pend_idx_q;
          found_key_d = ram_rdata;
        end
        if (pend_q && (pend_idx_q == '0)) begin
          first_key_d = ram_rdata;
        end
        if (issue) begin
          ram_re     = 1'b1;
          ram_raddr  = rd_idx_q[IW-1:0];
          pend_d     = 1'b1;
          pend_idx_d = rd_idx_q[IW-1:0];
          rd_idx_d   = rd_idx_q + CW'(1);
        end else begin
          pend_d = 1'b0;
          if (found_q) begin
            up_d = found_idx_q;
            nk_d = found_key_q;
          end else if (hit) begin
            up_d = pend_idx_q;
            nk_d = ram_rdata;
          end else begin
            // nothing later: wrap to the first entry
            up_d = '0;
            if (count_q == '0) begin
              nk_d = '0;
            end else if (pend_q && (pend_idx_q == '0)) begin
              nk_d = ram_rdata;
            end else begin
              nk_d = first_key_q;
            end
          end
          state_d = S_OUT;
        end
      end
      S_FETCH: begin
        nk_d    = (count_q != '0) ? ram_rdata : '0;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.status      = status_q;
          out_d.entry_count = 5'(count_q);
          out_d.next_index  = 4'(up_q);
          out_d.next_day    = nk_fields.day;
          out_d.next_hour   = nk_fields.hour;
          out_d.next_minute = nk_fields.minute;
          out_d.next_second = nk_fields.second;
          out_valid_d       = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      up_q        <= '0;
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      dup_q       <= 1'b0;
      found_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      up_q        <= up_d;
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      dup_q       <= dup_d;
      found_q     <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q       <= req_d;
    status_q    <= status_d;
    out_q       <= out_d;
    pend_idx_q  <= pend_idx_d;
    found_idx_q <= found_idx_d;
    found_key_q <= found_key_d;
    first_key_q <= first_key_d;
    ins_q       <= ins_d;
    nk_q        <= nk_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `SWET_ASSERT(a_count_bound, count_q <= DEPTH_C, "entry count above table depth")
  `SWET_ASSERT(a_next_in_table, (CW'(up_q) < count_q) || (up_q == '0), "next index past count")
  `SWET_ASSERT(a_no_rw_collide, !(ram_we && ram_re && (ram_waddr == ram_raddr)), "ram collision")
  `SWET_ASSERT_NEXT(a_place_grows, state_q == S_PLACE, count_q == $past(count_q) + CW'(1), "count not bumped")
  `SWET_ASSERT_IMPL(a_write_only_insert, ram_we, (state_q == S_SHIFT) || (state_q == S_PLACE), "stray ram write")

endmodule

[tb/sorted_weekly_event_table_tb.sv]
`timescale 1ns / 1ps

module sorted_weekly_event_table_tb;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned ITEMS_PER_PHASE = 250;
  localparam int unsigned HOLD_OFF_CYCLES = 400;

  // keeps its own copy of the sorted table and the pending responses
  class event_table_scoreboard;
    swet_pkg::key_t     keys[TABLE_DEPTH];
    int unsigned        held;
    int unsigned        upcoming;
    swet_pkg::out_rsp_t awaited_rsps[$];
    int unsigned        mismatches;

    function new();
      held = 0;
      upcoming = 0;
      mismatches = 0;
    endfunction

    function void find_upcoming(swet_pkg::key_t now_k);
      upcoming = 0;
      for (int i = 0; i < held; i++) begin
        if (now_k < keys[i]) begin
          upcoming = i;
          break;
        end
      end
    endfunction

    function void note_request(swet_pkg::in_req_t req);
      swet_pkg::key_t     ent;
      swet_pkg::key_t     now_k;
      swet_pkg::key_t     nk;
      swet_pkg::out_rsp_t rsp;
      swet_pkg::status_e  st;
      bit                 dup;
      int                 i;
      ent = {req.entry_day, req.entry_hour, req.entry_minute, req.entry_second};
      now_k.day    = 3'((int'(req.now_raw_day) + 6) % 7);
      now_k.hour   = req.now_hour;
      now_k.minute = req.now_minute;
      now_k.second = req.now_second;
      st = swet_pkg::ST_DONE;
      if (req.op == swet_pkg::OP_INSERT) begin
        dup = 1'b0;
        for (i = 0; i < held; i++) begin
          if (keys[i] == ent) dup = 1'b1;
        end
        if (dup) begin
          st = swet_pkg::ST_DUP;
        end else if (held >= TABLE_DEPTH) begin
          st = swet_pkg::ST_FULL;
        end else begin
          i = held;
          while (i > 0 && keys[i-1] > ent) begin
            keys[i] = keys[i-1];
            i--;
          end
          keys[i] = ent;
          held++;
          find_upcoming(now_k);
        end
      end else begin
        find_upcoming(now_k);
      end
      nk = (held > 0) ? keys[upcoming] : '0;
      rsp.status      = st;
      rsp.entry_count = 5'(held);
      rsp.next_index  = 4'(upcoming);
      rsp.next_day    = nk.day;
      rsp.next_hour   = nk.hour;
      rsp.next_minute = nk.minute;
      rsp.next_second = nk.second;
      awaited_rsps.push_back(rsp);
    endfunction

    function void check_response(swet_pkg::out_rsp_t got);
      swet_pkg::out_rsp_t exp;
      if (awaited_rsps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: response with no request pending", $realtime);
        return;
      end
      exp = awaited_rsps.pop_front();
      if (exp.status !== got.status || exp.entry_count !== got.entry_count ||
          exp.next_index !== got.next_index || exp.next_day !== got.next_day ||
          exp.next_hour !== got.next_hour || exp.next_minute !== got.next_minute ||
          exp.next_second !== got.next_second) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t: mismatch exp st=%0d cnt=%0d idx=%0d %0d %0d:%0d:%0d",
                   $realtime, exp.status, exp.entry_count, exp.next_index,
                   exp.next_day, exp.next_hour, exp.next_minute, exp.next_second);
          $display("%0t:          got st=%0d cnt=%0d idx=%0d %0d %0d:%0d:%0d",
                   $realtime, got.status, got.entry_count, got.next_index,
                   got.next_day, got.next_hour, got.next_minute, got.next_second);
        end
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  swet_pkg::in_req_t  in_req_i;
  logic               in_stall_o;
  logic               out_valid_o;
  swet_pkg::out_rsp_t out_rsp_o;
  logic               out_stall_i;

  event_table_scoreboard sb;
  int unsigned idle_pct;
  int unsigned stall_pct;
  bit          hold_off;
  int unsigned cycle_count;

  sorted_weekly_event_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_req_i   (in_req_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_rsp_o  (out_rsp_o),
    .out_stall_i(out_stall_i)
  );

  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      out_stall_i <= hold_off || ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_response(out_rsp_o);
    end
  end

  function automatic swet_pkg::in_req_t mk_req(logic op, int ed, int eh, int em, int es,
                                               int rd, int nh, int nm, int ns);
    swet_pkg::in_req_t r;
    r.op           = op;
    r.entry_day    = 3'(ed);
    r.entry_hour   = 5'(eh);
    r.entry_minute = 6'(em);
    r.entry_second = 6'(es);
    r.now_raw_day  = 3'(rd);
    r.now_hour     = 5'(nh);
    r.now_minute   = 6'(nm);
    r.now_second   = 6'(ns);
    return r;
  endfunction

  // mostly in-range times, often an exact copy of a held entry
  function automatic swet_pkg::in_req_t random_request();
    swet_pkg::in_req_t r;
    swet_pkg::key_t    k;
    int                pick;
    r.op = ($urandom_range(99) < 50) ? swet_pkg::OP_INSERT : swet_pkg::OP_REFRESH;
    pick = $urandom_range(99);
    if (pick < 45 && sb.held > 0) begin
      k = sb.keys[$urandom_range(sb.held - 1)];
    end else if (pick < 80) begin
      k = {3'($urandom_range(6)), 5'($urandom_range(23)),
           6'($urandom_range(59)), 6'($urandom_range(59))};
    end else begin
      k = swet_pkg::key_t'(20'($urandom));
    end
    r.entry_day    = k.day;
    r.entry_hour   = k.hour;
    r.entry_minute = k.minute;
    r.entry_second = k.second;
    pick = $urandom_range(99);
    if (pick < 35 && sb.held > 0) begin
      k = sb.keys[$urandom_range(sb.held - 1)];
      // raw clock day counts sunday as 0
      r.now_raw_day = (k.day == 3'd6) ? 3'd0 : k.day + 3'd1;
      r.now_hour    = k.hour;
      r.now_minute  = k.minute;
      r.now_second  = k.second;
    end else if (pick < 80) begin
      r.now_raw_day = 3'($urandom_range(6));
      r.now_hour    = 5'($urandom_range(23));
      r.now_minute  = 6'($urandom_range(59));
      r.now_second  = 6'($urandom_range(59));
    end else begin
      {r.now_raw_day, r.now_hour, r.now_minute, r.now_second} = 20'($urandom);
    end
    return r;
  endfunction

  task automatic send_request(input swet_pkg::in_req_t req);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(req);
  endtask

  task automatic idle_gap();
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
  endtask

  task automatic hold_receiver(input int unsigned cycles);
    hold_off = 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_off = 1'b0;
  endtask

  initial begin
    int unsigned sender_idle[5];
    int unsigned receiver_stall[5];
    sender_idle    = '{0, 49, 0, 22, 0};
    receiver_stall = '{0, 0, 49, 22, 0};
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    hold_off    = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    cycle_count = 0;
    sb = new();
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // refresh on an empty table
    send_request(mk_req(swet_pkg::OP_REFRESH, 0, 0, 0, 0, 3, 10, 20, 30));
    send_request(mk_req(swet_pkg::OP_INSERT, 6, 23, 59, 59, 1, 0, 0, 0));
    // now equal to an entry: only a strictly later one counts
    send_request(mk_req(swet_pkg::OP_INSERT, 0, 0, 0, 0, 1, 0, 0, 0));
    send_request(mk_req(swet_pkg::OP_INSERT, 0, 0, 0, 0, 2, 1, 1, 1));
    // no later entry, index falls back to 0
    send_request(mk_req(swet_pkg::OP_REFRESH, 0, 0, 0, 0, 0, 23, 59, 59));
    // all-ones fields, raw day 7
    send_request(mk_req(swet_pkg::OP_INSERT, 7, 31, 63, 63, 7, 31, 63, 63));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 12, 30, 15, 4, 12, 30, 15));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 12, 30, 16, 4, 12, 30, 15));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 12, 31, 15, 4, 12, 30, 15));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 13, 30, 15, 4, 12, 30, 15));
    send_request(mk_req(swet_pkg::OP_INSERT, 2, 31, 0, 0, 2, 5, 6, 7));
    send_request(mk_req(swet_pkg::OP_INSERT, 7, 31, 63, 63, 6, 0, 0, 0));
    send_request(mk_req(swet_pkg::OP_REFRESH, 0, 0, 0, 0, 5, 0, 0, 0));
    // fill the table at scattered positions
    send_request(mk_req(swet_pkg::OP_INSERT, 0, 0, 0, 1, 1, 0, 0, 0));
    send_request(mk_req(swet_pkg::OP_INSERT, 4, 0, 0, 0, 3, 8, 0, 0));
    send_request(mk_req(swet_pkg::OP_INSERT, 1, 1, 1, 1, 2, 1, 1, 1));
    send_request(mk_req(swet_pkg::OP_INSERT, 6, 23, 59, 58, 0, 23, 59, 58));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 12, 30, 14, 4, 12, 30, 14));
    send_request(mk_req(swet_pkg::OP_INSERT, 5, 10, 20, 30, 6, 9, 0, 0));
    send_request(mk_req(swet_pkg::OP_INSERT, 0, 31, 63, 63, 1, 31, 63, 62));
    send_request(mk_req(swet_pkg::OP_INSERT, 2, 0, 0, 0, 3, 0, 0, 0));
    // table full, then a duplicate on a full table
    send_request(mk_req(swet_pkg::OP_INSERT, 4, 4, 4, 4, 5, 4, 4, 4));
    send_request(mk_req(swet_pkg::OP_INSERT, 3, 12, 30, 15, 4, 0, 0, 0));
    send_request(mk_req(swet_pkg::OP_REFRESH, 0, 0, 0, 0, 6, 12, 0, 0));

    for (int ph = 0; ph < 5; ph++) begin
      idle_pct  = sender_idle[ph];
      stall_pct = receiver_stall[ph];
      if (ph == 4) begin
        fork
          hold_receiver(HOLD_OFF_CYCLES);
        join_none
      end
      repeat (ITEMS_PER_PHASE) begin
        idle_gap();
        send_request(random_request());
      end
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.awaited_rsps.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.awaited_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/swet_pkg.sv
design/swet_ram.sv
design/sorted_weekly_event_table.sv
tb/sorted_weekly_event_table_tb.sv
